/* rtl/dfs_adjacency_matrix_walk_top_assert.svh */
// ----------------------------------------------------------------------------
// DFS adjacency-matrix walk: assertion macros
// Concurrent assertion wrappers shared by the block; NO_ASSERTIONS drops them.
// ----------------------------------------------------------------------------
`ifndef DFS_ADJACENCY_MATRIX_WALK_TOP_ASSERT_SVH
`define DFS_ADJACENCY_MATRIX_WALK_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DFSAM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfsam assertion failed");

`define DFSAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfsam assertion failed");

`else

`define DFSAM_ASSERT_IMPLY(lbl, ante, cons)

`define DFSAM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/dfsam_pkg.sv */
// ----------------------------------------------------------------------------
// dfsam_pkg
// Widths, microcode encoding and control store of the DFS walk sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfsam_pkg;

    localparam int NODE_COUNT_W    = 5;
    localparam int IN_NODE_W       = 4;
    localparam int IO_VALUE_W      = 32;
    localparam int IO_ROW_W        = 16;
    localparam int MAX_NODES_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_RESULTS     = 16;
    localparam int RES_W           = 5;
    localparam int STEP_W          = 2;

    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_TRAVERSE = 1'b1;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 2'd0;
    localparam logic [STEP_W-1:0] STEP_START  = 2'd1;
    localparam logic [STEP_W-1:0] STEP_SEARCH = 2'd2;
    localparam logic [STEP_W-1:0] STEP_FINAL  = 2'd3;

    localparam logic [1:0] ACT_ACCEPT = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_SEARCH = 2'd2;
    localparam logic [1:0] ACT_FINAL  = 2'd3;

    localparam logic [1:0] COND_GO       = 2'd0;
    localparam logic [1:0] COND_ALWAYS   = 2'd1;
    localparam logic [1:0] COND_WALK_END = 2'd2;
    localparam logic [1:0] COND_OUT_FREE = 2'd3;

    typedef struct packed {
        logic [1:0]        act;
        logic [1:0]        cond;
        logic [STEP_W-1:0] jump;
        logic [STEP_W-1:0] next;
    } ucode_t;

    typedef struct packed {
        logic go;
        logic walk_end;
        logic out_free;
    } seq_status_t;

    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t cw;
        case (step)
            STEP_IDLE:   cw = '{ACT_ACCEPT, COND_GO,       STEP_START,  STEP_IDLE};
            STEP_START:  cw = '{ACT_START,  COND_ALWAYS,   STEP_SEARCH, STEP_SEARCH};
            STEP_SEARCH: cw = '{ACT_SEARCH, COND_WALK_END, STEP_FINAL,  STEP_SEARCH};
            STEP_FINAL:  cw = '{ACT_FINAL,  COND_OUT_FREE, STEP_IDLE,   STEP_FINAL};
            default:     cw = '{ACT_ACCEPT, COND_GO,       STEP_START,  STEP_IDLE};
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

/* rtl/dfs_adjacency_matrix_walk_top.sv */
// ----------------------------------------------------------------------------
// dfs_adjacency_matrix_walk_top
// Preorder depth-first walk over a node table held as adjacency-matrix rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one word per item. operation 0
//   loads node_value and adjacency_row for node_index; in_ready stays high.
//   operation 1 walks from start_node; the input channel stays closed
//   until the walk has handed its last word to the output register.
//   Output channel (out_valid/out_ready) gives one word per visited node,
//   lowest-numbered unvisited neighbor first; last_of_run marks the final one.
//   The first word enters the output register at the first push, or in the
//   final step if the start has no unvisited neighbor. The walk takes one
//   search step per push and one per pop. A start at or beyond node_count
//   gives no word. A receiver stall holds the output register and stalls
//   the walk at its next push or at its final word.
//   cfg_write_en/cfg_write_data set node_count; write only while idle.
//   Reset: node table and visited map clear, node_count is 16.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dfs_adjacency_matrix_walk_top_assert.svh"

module dfs_adjacency_matrix_walk_top #(
    parameter int MAX_NODES   = dfsam_pkg::MAX_NODES_DEF,
    parameter int VALUE_WIDTH = dfsam_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  operation,
    input  wire logic [dfsam_pkg::IN_NODE_W-1:0]       node_index,
    input  wire logic signed [dfsam_pkg::IO_VALUE_W-1:0] node_value,
    input  wire logic [dfsam_pkg::IO_ROW_W-1:0]        adjacency_row,
    input  wire logic [dfsam_pkg::IN_NODE_W-1:0]       start_node,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [dfsam_pkg::IN_NODE_W-1:0]            visited_node,
    output logic signed [dfsam_pkg::IO_VALUE_W-1:0]    visited_value,
    output logic                                       last_of_run,
    input  wire logic                                  cfg_write_en,
    input  wire logic [dfsam_pkg::NODE_COUNT_W-1:0]    cfg_write_data
);
    import dfsam_pkg::*;

    localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DEPTH_W = $clog2(MAX_NODES + 1);
    localparam int CW      = (DEPTH_W > NODE_COUNT_W) ? DEPTH_W : NODE_COUNT_W;

    logic [MAX_NODES-1:0]          adj_rows_reg [MAX_NODES];
    logic signed [VALUE_WIDTH-1:0] values_reg   [MAX_NODES];
    logic [NODE_W-1:0]             stack_reg    [MAX_NODES];
    logic [MAX_NODES-1:0]          visited_reg;
    logic [DEPTH_W-1:0]            depth_reg;
    logic [RES_W-1:0]              k_reg;
    logic [NODE_W-1:0]             pend_reg;
    logic [NODE_COUNT_W-1:0]       node_count_reg;

    logic                          out_valid_reg;
    logic [IN_NODE_W-1:0]          out_node_reg;
    logic signed [IO_VALUE_W-1:0]  out_value_reg;
    logic                          out_last_reg;

    ucode_t                        cw;
    seq_status_t                   status;

    logic [CW-1:0]                 n_eff;
    logic [CW-1:0]                 nc_ext;
    logic [MAX_NODES-1:0]          node_mask;
    logic                          start_ok;
    logic                          load_ok;
    logic                          in_fire;
    logic                          out_free;
    logic                          out_load;
    logic [DEPTH_W-1:0]            depth_m1;
    logic [NODE_W-1:0]             top_node;
    logic [MAX_NODES-1:0]          cand;
    logic                          found;
    logic [NODE_W-1:0]             found_j;
    logic                          can_push;
    logic [63:0]                   start_wide;
    logic [63:0]                   index_wide;
    logic [63:0]                   row_wide;
    logic signed [63:0]            value_in_wide;
    logic signed [63:0]            value_out_wide;
    logic [63:0]                   pend_wide;

    dfsam_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cw     (cw)
    );

    assign in_ready      = (cw.act == ACT_ACCEPT);
    assign in_fire       = in_valid && in_ready;
    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign visited_node  = out_node_reg;
    assign visited_value = out_value_reg;
    assign last_of_run   = out_last_reg;

    assign start_wide     = 64'(start_node);
    assign index_wide     = 64'(node_index);
    assign row_wide       = 64'(adjacency_row);
    assign value_in_wide  = 64'(node_value);
    assign value_out_wide = 64'(values_reg[pend_reg]);
    assign pend_wide      = 64'(pend_reg);

    always_comb
    begin
        nc_ext = CW'(node_count_reg);
        n_eff  = (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            node_mask[i] = (CW'(i) < n_eff);
        end
    end

    assign start_ok = (CW'(start_node) < n_eff);
    assign load_ok  = (CW'(node_index) < CW'(MAX_NODES));

    assign depth_m1 = depth_reg - 1'b1;
    assign top_node = stack_reg[depth_m1[NODE_W-1:0]];
    assign cand     = adj_rows_reg[top_node] & ~visited_reg & node_mask;

    // lowest set candidate wins
    always_comb
    begin
        found   = 1'b0;
        found_j = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found   = 1'b1;
                found_j = NODE_W'(i);
            end
        end
    end

    assign can_push = found && (depth_reg < DEPTH_W'(MAX_NODES))
                      && (k_reg != RES_W'(MAX_RESULTS));

    assign out_load = ((cw.act == ACT_SEARCH) && can_push && out_free)
                      || ((cw.act == ACT_FINAL) && out_free);

    assign status.go       = in_fire && (operation == OP_TRAVERSE) && start_ok;
    assign status.walk_end = (k_reg == RES_W'(MAX_RESULTS))
                             || (!can_push && (depth_reg == DEPTH_W'(1)));
    assign status.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else if (cfg_write_en)
        begin
            node_count_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES; i++)
            begin
                adj_rows_reg[i] <= '0;
                values_reg[i]   <= '0;
            end
        end
        else if (in_fire && (operation == OP_LOAD) && load_ok)
        begin
            adj_rows_reg[index_wide[NODE_W-1:0]] <= row_wide[MAX_NODES-1:0];
            values_reg[index_wide[NODE_W-1:0]]   <= value_in_wide[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // walk datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg   <= '0;
            depth_reg     <= '0;
            k_reg         <= '0;
        end
        else
        begin
            case (cw.act)
                ACT_ACCEPT:
                begin
                    if (in_fire && (operation == OP_TRAVERSE))
                    begin
                        visited_reg <= '0;
                        depth_reg   <= '0;
                        k_reg       <= '0;
                    end
                end
                ACT_START:
                begin
                    visited_reg[pend_reg] <= 1'b1;
                    depth_reg             <= DEPTH_W'(1);
                    k_reg                 <= RES_W'(1);
                end
                ACT_SEARCH:
                begin
                    if (can_push)
                    begin
                        if (out_free)
                        begin
                            visited_reg[found_j] <= 1'b1;
                            depth_reg            <= depth_reg + 1'b1;
                            k_reg                <= k_reg + 1'b1;
                        end
                    end
                    else if (k_reg != RES_W'(MAX_RESULTS))
                    begin
                        depth_reg <= depth_m1;
                    end
                end
                ACT_FINAL:
                begin
                    if (out_free)
                    begin
                        depth_reg     <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cw.act)
            ACT_ACCEPT:
            begin
                if (in_fire)
                begin
                    pend_reg <= start_wide[NODE_W-1:0];
                end
            end
            ACT_START:
            begin
                stack_reg[0] <= pend_reg;
            end
            ACT_SEARCH:
            begin
                if (can_push && out_free)
                begin
                    out_node_reg  <= pend_wide[IN_NODE_W-1:0];
                    out_value_reg <= value_out_wide[IO_VALUE_W-1:0];
                    out_last_reg  <= 1'b0;
                    pend_reg      <= found_j;
                    stack_reg[depth_reg[NODE_W-1:0]] <= found_j;
                end
            end
            ACT_FINAL:
            begin
                if (out_free)
                begin
                    out_node_reg  <= pend_wide[IN_NODE_W-1:0];
                    out_value_reg <= value_out_wide[IO_VALUE_W-1:0];
                    out_last_reg  <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    `DFSAM_ASSERT_IMPLY(a_idle_stack_empty, in_ready, depth_reg == '0)
    `DFSAM_ASSERT_IMPLY(a_depth_bound, 1'b1, depth_reg <= DEPTH_W'(MAX_NODES))
    `DFSAM_ASSERT_IMPLY(a_result_bound, 1'b1, k_reg <= RES_W'(MAX_RESULTS))
    `DFSAM_ASSERT_NEXT(a_push_emits, (cw.act == ACT_SEARCH) && can_push && out_free, out_valid)

endmodule

`default_nettype wire

/* rtl/dfsam_sequencer.sv */
// ----------------------------------------------------------------------------
// dfsam_sequencer
// Step counter over the control store; one conditional jump per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dfsam_sequencer (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dfsam_pkg::seq_status_t status,
    output dfsam_pkg::ucode_t          cw
);
    import dfsam_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              cond_true;

    assign cw = ucode_rom(step_reg);

    always_comb
    begin
        case (cw.cond)
            COND_GO:       cond_true = status.go;
            COND_ALWAYS:   cond_true = 1'b1;
            COND_WALK_END: cond_true = status.walk_end;
            COND_OUT_FREE: cond_true = status.out_free;
            default:       cond_true = 1'b0;
        endcase
        step_next = cond_true ? cw.jump : cw.next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire
